// File: design/tdpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpt_pkg
// shared constants and types for the trial division prime tester
// ----------------------------------------------------------------------------
package tdpt_pkg;

    // default width of the tested value
    localparam int unsigned VALUE_WIDTH_DEF = 31;

    // status from the serial divider to the controller
    typedef struct packed {
        logic busy;  // a division is in progress
        logic done;  // quotient and remainder valid this cycle
    } t_div_stat;

endpackage

// File: design/tdpt_serial_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpt_serial_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module tdpt_serial_div #(
    parameter int unsigned VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [VALUE_WIDTH-1:0] i_dividend,
    input  logic [VALUE_WIDTH-1:0] i_divisor,   // held stable while busy
    output tdpt_pkg::t_div_stat    o_stat,
    output logic [VALUE_WIDTH-1:0] o_quotient,
    output logic [VALUE_WIDTH-1:0] o_remainder
);
    import tdpt_pkg::*;

    localparam int unsigned CntW = $clog2(VALUE_WIDTH);
    localparam logic [CntW-1:0] LastStep = CntW'(VALUE_WIDTH - 1);

    logic [VALUE_WIDTH-1:0] r_rem, n_rem;
    logic [VALUE_WIDTH-1:0] r_quo, n_quo;
    logic [CntW-1:0]        r_cnt, n_cnt;
    logic                   r_busy, n_busy;
    logic                   r_done, n_done;

    logic [VALUE_WIDTH:0]   w_trial;
    logic [VALUE_WIDTH:0]   w_diff;
    logic                   w_fits;

    // shift in the next dividend bit and try one subtraction
    assign w_trial = {r_rem, r_quo[VALUE_WIDTH-1]};
    assign w_diff  = w_trial - {1'b0, i_divisor};
    assign w_fits  = ~w_diff[VALUE_WIDTH];

    always_comb begin
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_rem  = '0;
            n_quo  = i_dividend;
            n_cnt  = LastStep;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem = w_fits ? w_diff[VALUE_WIDTH-1:0] : w_trial[VALUE_WIDTH-1:0];
            n_quo = {r_quo[VALUE_WIDTH-2:0], w_fits};
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_rem  <= '0;
            r_quo  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
            r_rem  <= n_rem;
            r_quo  <= n_quo;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

// File: design/trial_division_prime_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trial_division_prime_test
// primality test of one unsigned value by trial division
// ----------------------------------------------------------------------------
// Takes one candidate per input beat and returns one beat with the candidate
// echoed and a prime flag. Zero and one are reported not prime at once, the
// result beat offered in the cycle right after the input beat. Otherwise
// divisors 2, 3, 4 and upward are tried in turn on a bit-serial restoring
// divider; each trial passes through a start state, then the divider
// produces one quotient bit per cycle, then the result is checked. The
// search stops when the divisor exceeds the quotient (divisor past the
// square root, so prime) or when a remainder is zero (not prime). For the
// default width the worst case is a prime just below 2^31, with about
// 46341 trials. One item is in work at a time: the input is ready only
// when no test runs and no result waits.
// ----------------------------------------------------------------------------
module trial_division_prime_test #(
    parameter int unsigned VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    // input stream
    input  logic                                     s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  logic [((VALUE_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,  // candidate
    // output stream
    output logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    output logic [((VALUE_WIDTH + 8) / 8) * 8 - 1:0] m_axis_tdata   // tested_value, is_prime
);
    import tdpt_pkg::*;

    localparam int unsigned OutW = ((VALUE_WIDTH + 8) / 8) * 8;
    localparam logic [VALUE_WIDTH-1:0] FirstDivisor = VALUE_WIDTH'(2);

    typedef enum logic [1:0] {
        ST_IDLE,   // waiting for a candidate
        ST_START,  // launch one division
        ST_WAIT,   // divider shifting
        ST_DONE    // result beat offered
    } t_state;

    t_state                 r_state;
    logic [VALUE_WIDTH-1:0] r_cand;      // candidate under test, also echoed
    logic [VALUE_WIDTH-1:0] r_divisor;   // current trial divisor
    logic                   r_prime;

    t_div_stat              w_stat;
    logic [VALUE_WIDTH-1:0] w_quo;
    logic [VALUE_WIDTH-1:0] w_rem;
    logic [VALUE_WIDTH-1:0] w_in_cand;
    logic                   w_in_beat;

    assign w_in_cand = s_axis_tdata[VALUE_WIDTH-1:0];
    assign w_in_beat = s_axis_tvalid & s_axis_tready;

    tdpt_serial_div #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (r_state == ST_START),
        .i_dividend  (r_cand),
        .i_divisor   (r_divisor),
        .o_stat      (w_stat),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    // sequencer: one divisor per division pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cand    <= '0;
            r_divisor <= '0;
            r_prime   <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_beat) begin
                        r_cand    <= w_in_cand;
                        r_divisor <= FirstDivisor;
                        // zero and one never reach the divider
                        if (w_in_cand[VALUE_WIDTH-1:1] == '0) begin
                            r_prime <= 1'b0;
                            r_state <= ST_DONE;
                        end else begin
                            r_state <= ST_START;
                        end
                    end
                end
                ST_START: begin
                    r_state <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (w_stat.done) begin
                        priority if (r_divisor > w_quo) begin
                            // divisor past the square root
                            r_prime <= 1'b1;
                            r_state <= ST_DONE;
                        end else if (w_rem == '0) begin
                            r_prime <= 1'b0;
                            r_state <= ST_DONE;
                        end else begin
                            r_divisor <= r_divisor + 1'b1;
                            r_state   <= ST_START;
                        end
                    end
                end
                ST_DONE: begin
                    if (m_axis_tready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = (r_state == ST_DONE);
    // zero padding above the flag
    assign m_axis_tdata  = OutW'({r_prime, r_cand});

endmodule

// File: design/tdpt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpt_checker
// port-level checks of the prime tester, bound to the top level
// ----------------------------------------------------------------------------
module tdpt_checker #(
    parameter int unsigned VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH_DEF
) (
    input logic                                     i_clk,
    input logic                                     i_rst_n,
    input logic                                     s_axis_tvalid,
    input logic                                     s_axis_tready,
    input logic [((VALUE_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
    input logic                                     m_axis_tvalid,
    input logic                                     m_axis_tready,
    input logic [((VALUE_WIDTH + 8) / 8) * 8 - 1:0] m_axis_tdata
);
    import tdpt_pkg::*;

    // a pending result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat dropped or changed while stalled");

    // one item in flight: never ready while a result waits
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while result pending");

    // an accepted beat closes the input
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input stayed ready after a beat");

    // zero and one answered at once, not prime, value echoed
    a_small: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tdata[VALUE_WIDTH-1:1] == '0)
        |=> m_axis_tvalid && !m_axis_tdata[VALUE_WIDTH]
            && (m_axis_tdata[VALUE_WIDTH-1:0] == $past(s_axis_tdata[VALUE_WIDTH-1:0])))
        else $error("zero or one not reported as not prime");

    // a taken result reopens the input
    a_reopen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready |=> s_axis_tready)
        else $error("input not ready after result beat");

endmodule

bind trial_division_prime_test tdpt_checker #(
    .VALUE_WIDTH(VALUE_WIDTH)
) u_tdpt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
